// File: src/bb_pkg.sv
package bb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int HEIGHT_CAP = 4096;

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int FW_W  = 12;
  localparam int FH_W  = 13;
  localparam int ROW_W = FH_W;
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = ((COL_W > FW_W) ? COL_W : FW_W) + 1;
  localparam int POS_W = $clog2(MAX_WIDTH * HEIGHT_CAP);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = FH_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;
  localparam int RST_AREA_M1 = RST_WIDTH * RST_HEIGHT - 1;

  localparam int SUM_W  = $clog2(9 * 255 + 9);
  localparam int CNT_W  = 4;
  localparam int FRAC_W = 14;
  localparam int K_W    = FRAC_W + 1;
  localparam int PROD_W = SUM_W + K_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic emit;
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
    logic last;
  } win_ctl_t;

  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [CNT_W-1:0]      cnt;
    logic                  last;
  } sum_beat_t;

  typedef struct packed {
    logic [2:0][CH_W-1:0] ch;
    logic                 last;
  } out_beat_t;

  function automatic logic [FW_W-1:0] eff_width(input logic [FW_W-1:0] v);
    logic [FW_W-1:0] w;
    if (v == '0) begin
      w = FW_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      w = FW_W'(MAX_WIDTH);
    end else begin
      w = v;
    end
    return w;
  endfunction

  function automatic logic [FH_W-1:0] eff_height(input logic [FH_W-1:0] v);
    logic [FH_W-1:0] h;
    if (v == '0) begin
      h = FH_W'(1);
    end else if (int'(v) > HEIGHT_CAP) begin
      h = FH_W'(HEIGHT_CAP);
    end else begin
      h = v;
    end
    return h;
  endfunction

  // 2^FRAC_W / count, rounded up
  function automatic logic [K_W-1:0] recip_k(input logic [CNT_W-1:0] cnt);
    logic [K_W-1:0] k;
    case (cnt)
      CNT_W'(1): k = K_W'(16384);
      CNT_W'(2): k = K_W'(8192);
      CNT_W'(3): k = K_W'(5462);
      CNT_W'(4): k = K_W'(4096);
      CNT_W'(6): k = K_W'(2731);
      CNT_W'(9): k = K_W'(1821);
      default:   k = '0;
    endcase
    return k;
  endfunction

endpackage

// File: src/bb_ifs.sv
interface bb_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [bb_pkg::CH_W-1:0]   in_red;
  logic [bb_pkg::CH_W-1:0]   in_green;
  logic [bb_pkg::CH_W-1:0]   in_blue;
  logic                      flush;

  modport source (output valid, in_red, in_green, in_blue, flush, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, flush, output ready);
endinterface

interface bb_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [bb_pkg::CH_W-1:0]   out_red;
  logic [bb_pkg::CH_W-1:0]   out_green;
  logic [bb_pkg::CH_W-1:0]   out_blue;
  logic                      frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface bb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bb_pkg::CFG_IDX_W-1:0]  index;
  logic [bb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/bb_line_ram.sv
module bb_line_ram (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [bb_pkg::COL_W-1:0]   rd_addr,
  output logic [2*bb_pkg::PIX_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [bb_pkg::COL_W-1:0]   wr_addr,
  input  logic [2*bb_pkg::PIX_W-1:0] wr_data
);

  logic [2*bb_pkg::PIX_W-1:0] mem [bb_pkg::MAX_WIDTH];
  logic [2*bb_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/bb_window.sv
module bb_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                col_valid,
  input  bb_pkg::win_ctl_t    col_ctl,
  input  bb_pkg::pix_t        top_pix,
  input  bb_pkg::pix_t        mid_pix,
  input  bb_pkg::pix_t        bot_pix,
  output logic                sum_valid,
  output bb_pkg::sum_beat_t   sum_beat
);

  bb_pkg::pix_t win_r   [3][3];
  bb_pkg::pix_t win_nxt [3][3];

  logic                      sum_valid_r;
  bb_pkg::sum_beat_t         sum_beat_r;
  bb_pkg::sum_beat_t         sum_beat_nxt;
  logic [2:0]                row_ok;
  logic [2:0]                col_ok;
  logic [1:0]                rows_n;
  logic [1:0]                cols_n;
  logic [bb_pkg::SUM_W-1:0]  row_sum [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_nxt[r][c] = win_r[r][c];
      end
    end
    if (col_valid) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r][0] = win_r[r][1];
        win_nxt[r][1] = win_r[r][2];
      end
      win_nxt[0][2] = top_pix;
      win_nxt[1][2] = mid_pix;
      win_nxt[2][2] = bot_pix;
    end
  end

  always_comb begin
    row_ok = {col_ctl.bot_ok, 1'b1, col_ctl.top_ok};
    col_ok = {col_ctl.right_ok, 1'b1, col_ctl.left_ok};
    rows_n = 2'd1 + 2'(col_ctl.top_ok) + 2'(col_ctl.bot_ok);
    cols_n = 2'd1 + 2'(col_ctl.left_ok) + 2'(col_ctl.right_ok);

    for (int r = 0; r < 3; r++) begin
      for (int ch = 0; ch < 3; ch++) begin
        row_sum[r][ch] = '0;
        for (int c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            row_sum[r][ch] = row_sum[r][ch]
                           + bb_pkg::SUM_W'(win_nxt[r][c][bb_pkg::CH_W*ch +: bb_pkg::CH_W]);
          end
        end
      end
    end

    for (int ch = 0; ch < 3; ch++) begin
      sum_beat_nxt.sum[ch] = row_sum[0][ch] + row_sum[1][ch] + row_sum[2][ch];
    end
    sum_beat_nxt.cnt  = bb_pkg::CNT_W'(rows_n) * bb_pkg::CNT_W'(cols_n);
    sum_beat_nxt.last = col_ctl.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
      sum_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      sum_valid_r <= col_valid && col_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    sum_beat_r <= sum_beat_nxt;
  end

  assign sum_valid = sum_valid_r;
  assign sum_beat  = sum_beat_r;

endmodule

// File: src/bb_norm.sv
module bb_norm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bb_pkg::sum_beat_t  in_beat,
  output logic               out_valid,
  output bb_pkg::out_beat_t  out_beat
);

  logic                       out_valid_r;
  bb_pkg::out_beat_t          out_beat_r;
  bb_pkg::out_beat_t          out_beat_nxt;
  logic [bb_pkg::K_W-1:0]     k;
  logic [bb_pkg::SUM_W-1:0]   z    [3];
  logic [bb_pkg::PROD_W-1:0]  prod [3];

  // mean rounded half up: floor((sum + cnt/2) / cnt) by reciprocal multiply
  always_comb begin
    k = bb_pkg::recip_k(in_beat.cnt);
    for (int ch = 0; ch < 3; ch++) begin
      z[ch]    = in_beat.sum[ch] + bb_pkg::SUM_W'(in_beat.cnt >> 1);
      prod[ch] = bb_pkg::PROD_W'(z[ch]) * bb_pkg::PROD_W'(k);
      out_beat_nxt.ch[ch] = prod[ch][bb_pkg::FRAC_W +: bb_pkg::CH_W];
    end
    out_beat_nxt.last = in_beat.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// File: src/bb_out_fifo.sv
module bb_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_valid,
  input  bb_pkg::out_beat_t           wr_beat,
  output logic                        rd_valid,
  input  logic                        rd_ready,
  output bb_pkg::out_beat_t           rd_beat,
  output logic [bb_pkg::FIFO_CW-1:0]  count
);

  bb_pkg::out_beat_t             mem [bb_pkg::FIFO_DEPTH];
  logic [bb_pkg::FIFO_AW-1:0]    wr_ptr_r;
  logic [bb_pkg::FIFO_AW-1:0]    wr_ptr_nxt;
  logic [bb_pkg::FIFO_AW-1:0]    rd_ptr_r;
  logic [bb_pkg::FIFO_AW-1:0]    rd_ptr_nxt;
  logic [bb_pkg::FIFO_CW-1:0]    count_r;
  logic [bb_pkg::FIFO_CW-1:0]    count_nxt;
  logic                          pop;

  assign pop = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_valid) begin
      wr_ptr_nxt = wr_ptr_r + bb_pkg::FIFO_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + bb_pkg::FIFO_AW'(1);
    end
    if (wr_valid && !pop) begin
      count_nxt = count_r + bb_pkg::FIFO_CW'(1);
    end else if (!wr_valid && pop) begin
      count_nxt = count_r - bb_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr_r] <= wr_beat;
    end
  end

  assign rd_valid = (count_r != '0);
  assign rd_beat  = mem[rd_ptr_r];
  assign count    = count_r;

endmodule

// File: src/box_blur_3x3.sv
// 3x3 box blur over an RGB pixel stream, neighbors outside the frame left out.
// in_pix carries one pixel per beat in raster order; flush = 1 marks a drain
// beat with no pixel. After the last pixel of a frame send frame_width + 1
// flush beats to drain the final results. out_pix carries one blurred pixel
// per beat; frame_end marks the last pixel of the frame. cfg_wr writes
// frame_width (index 0) or frame_height (index 1); write them only while the
// block is idle, which the block does not enforce. Each write restarts the
// frame; cfg_wr.ready is always high. Throughput: one beat per cycle. A result
// passes line buffer read, window sum, reciprocal multiply and output queue
// after the beat that completes its window, width + 1 beats behind its pixel.
// The two previous rows share one single-port-read RAM of MAX_WIDTH entries,
// read and written back at the same column each beat.
// When out_pix stalls, results collect in an 8-entry queue and in_pix.ready
// drops once the queue plus the beats in flight would fill it; nothing is lost.
// Reset: width 640, height 480, counters and window cleared. The line RAM is
// not cleared; entries never written only feed masked neighbors.
module box_blur_3x3 (
  input  logic          clk,
  input  logic          rst_n,
  bb_pix_in_if.sink     in_pix,
  bb_pix_out_if.source  out_pix,
  bb_cfg_if.sink        cfg_wr
);

  logic                        in_acc;
  logic                        cfg_acc;
  logic                        cfg_hit;

  logic [bb_pkg::FW_W-1:0]     eff_w_r;
  logic [bb_pkg::FW_W-1:0]     eff_w_nxt;
  logic [bb_pkg::FH_W-1:0]     eff_h_r;
  logic [bb_pkg::FH_W-1:0]     eff_h_nxt;
  logic [bb_pkg::POS_W-1:0]    area_r;
  logic [bb_pkg::POS_W-1:0]    area_nxt;
  logic [bb_pkg::FW_W+bb_pkg::FH_W-1:0] area_prod;

  logic [bb_pkg::COL_W-1:0]    col_r;
  logic [bb_pkg::COL_W-1:0]    col_nxt;
  logic [bb_pkg::ROW_W-1:0]    row_r;
  logic [bb_pkg::ROW_W-1:0]    row_nxt;
  logic [bb_pkg::POS_W-1:0]    pos_r;
  logic [bb_pkg::POS_W-1:0]    pos_nxt;

  logic [bb_pkg::CMP_W-1:0]    w_ext;
  logic [bb_pkg::CMP_W-1:0]    col_p1;
  logic [bb_pkg::CMP_W-1:0]    oc;
  logic [bb_pkg::ROW_W-1:0]    orow;
  bb_pkg::win_ctl_t            ctl;
  bb_pkg::pix_t                in_px;

  logic                        s1_valid_r;
  bb_pkg::pix_t                s1_pix_r;
  logic [bb_pkg::COL_W-1:0]    s1_col_r;
  bb_pkg::win_ctl_t            s1_ctl_r;
  logic                        fwd_r;
  logic [2*bb_pkg::PIX_W-1:0]  fwd_data_r;

  logic [2*bb_pkg::PIX_W-1:0]  ram_q;
  logic [2*bb_pkg::PIX_W-1:0]  col_rd;
  logic [2*bb_pkg::PIX_W-1:0]  wr_data;
  bb_pkg::pix_t                col_up;
  bb_pkg::pix_t                col_mid;

  logic                        sum_valid;
  bb_pkg::sum_beat_t           sum_beat;
  logic                        norm_valid;
  bb_pkg::out_beat_t           norm_beat;
  bb_pkg::out_beat_t           rd_beat;
  logic [bb_pkg::FIFO_CW-1:0]  fifo_cnt;
  logic [bb_pkg::FIFO_CW:0]    occupancy;

  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid && cfg_wr.ready;
  assign cfg_hit      = cfg_acc && ((cfg_wr.index == bb_pkg::REG_FRAME_WIDTH) ||
                                    (cfg_wr.index == bb_pkg::REG_FRAME_HEIGHT));
  assign in_acc       = in_pix.valid && in_pix.ready;

  // frame geometry, area kept as width * height - 1
  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (cfg_acc) begin
      case (cfg_wr.index)
        bb_pkg::REG_FRAME_WIDTH: begin
          eff_w_nxt = bb_pkg::eff_width(cfg_wr.data[bb_pkg::FW_W-1:0]);
        end
        bb_pkg::REG_FRAME_HEIGHT: begin
          eff_h_nxt = bb_pkg::eff_height(cfg_wr.data[bb_pkg::FH_W-1:0]);
        end
        default: begin
        end
      endcase
    end
    area_prod = eff_w_nxt * eff_h_nxt;
    area_nxt  = bb_pkg::POS_W'(area_prod - (bb_pkg::FW_W + bb_pkg::FH_W)'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= bb_pkg::FW_W'(bb_pkg::RST_WIDTH);
      eff_h_r <= bb_pkg::FH_W'(bb_pkg::RST_HEIGHT);
      area_r  <= bb_pkg::POS_W'(bb_pkg::RST_AREA_M1);
    end else if (cfg_hit) begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      area_r  <= area_nxt;
    end
  end

  // output position of the window this beat completes
  always_comb begin
    w_ext  = bb_pkg::CMP_W'(eff_w_r);
    col_p1 = bb_pkg::CMP_W'(col_r) + bb_pkg::CMP_W'(1);
    if (col_r == '0) begin
      oc   = w_ext - bb_pkg::CMP_W'(1);
      orow = row_r - bb_pkg::ROW_W'(2);
    end else begin
      oc   = bb_pkg::CMP_W'(col_r) - bb_pkg::CMP_W'(1);
      orow = row_r - bb_pkg::ROW_W'(1);
    end
    ctl.emit     = (row_r >= bb_pkg::ROW_W'(2)) ||
                   ((row_r == bb_pkg::ROW_W'(1)) && (col_r != '0));
    ctl.left_ok  = (oc != '0);
    ctl.right_ok = ((oc + bb_pkg::CMP_W'(1)) < w_ext);
    ctl.top_ok   = (orow != '0);
    ctl.bot_ok   = (({1'b0, orow} + (bb_pkg::ROW_W+1)'(1)) < {1'b0, eff_h_r});
    ctl.last     = (pos_r >= area_r);

    in_px = in_pix.flush ? '0 : {in_pix.in_red, in_pix.in_green, in_pix.in_blue};
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    pos_nxt = pos_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
      pos_nxt = '0;
    end else if (in_acc) begin
      if (ctl.emit && ctl.last) begin
        col_nxt = '0;
        row_nxt = '0;
        pos_nxt = '0;
      end else begin
        if (ctl.emit) begin
          pos_nxt = pos_r + bb_pkg::POS_W'(1);
        end
        if (col_p1 >= w_ext) begin
          col_nxt = '0;
          row_nxt = row_r + bb_pkg::ROW_W'(1);
        end else begin
          col_nxt = col_p1[bb_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pos_r <= pos_nxt;
    end
  end

  // line buffer: read the column at accept, write it back in the next cycle
  assign col_rd  = fwd_r ? fwd_data_r : ram_q;
  assign col_up  = col_rd[2*bb_pkg::PIX_W-1:bb_pkg::PIX_W];
  assign col_mid = col_rd[bb_pkg::PIX_W-1:0];
  assign wr_data = {col_mid, s1_pix_r};

  bb_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (ram_q),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      fwd_r      <= in_acc && s1_valid_r && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_px;
      s1_col_r   <= col_r;
      s1_ctl_r   <= ctl;
      fwd_data_r <= wr_data;
    end
  end

  bb_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_valid (s1_valid_r),
    .col_ctl   (s1_ctl_r),
    .top_pix   (col_up),
    .mid_pix   (col_mid),
    .bot_pix   (s1_pix_r),
    .sum_valid (sum_valid),
    .sum_beat  (sum_beat)
  );

  bb_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid),
    .in_beat   (sum_beat),
    .out_valid (norm_valid),
    .out_beat  (norm_beat)
  );

  bb_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (norm_valid),
    .wr_beat  (norm_beat),
    .rd_valid (out_pix.valid),
    .rd_ready (out_pix.ready),
    .rd_beat  (rd_beat),
    .count    (fifo_cnt)
  );

  // hold input while queued plus in-flight beats could fill the queue
  assign occupancy = {1'b0, fifo_cnt}
                   + (bb_pkg::FIFO_CW+1)'(s1_valid_r)
                   + (bb_pkg::FIFO_CW+1)'(sum_valid)
                   + (bb_pkg::FIFO_CW+1)'(norm_valid);
  assign in_pix.ready = (occupancy < (bb_pkg::FIFO_CW+1)'(bb_pkg::FIFO_DEPTH));

  assign out_pix.out_red   = rd_beat.ch[2];
  assign out_pix.out_green = rd_beat.ch[1];
  assign out_pix.out_blue  = rd_beat.ch[0];
  assign out_pix.frame_end = rd_beat.last;

endmodule

// File: bench/box_blur_3x3_tb.sv
`timescale 1ns / 1ps

module box_blur_3x3_tb;
  import bb_pkg::*;

  localparam int RANDOM_BEATS = 1430;
  localparam int QUIET_BEATS  = 200;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_WAIT   = 16;
  localparam int END_LIMIT    = 20000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } blurred_t;

  class blur_scoreboard;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    pix_t            upper_line [MAX_WIDTH];
    pix_t            middle_line [MAX_WIDTH];
    pix_t            win [3][3];
    int unsigned     col;
    int unsigned     row;
    int unsigned     out_count;
    blurred_t        blurred_q [$];
    int              errors;
    int              checked;

    function new();
      width_reg  = FW_W'(RST_WIDTH);
      height_reg = FH_W'(RST_HEIGHT);
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col       = 0;
      row       = 0;
      out_count = 0;
      errors    = 0;
      checked   = 0;
    endfunction

    function int pending();
      return blurred_q.size();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = val[FW_W-1:0];
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = val[FH_W-1:0];
      end else begin
        return;
      end
      col       = 0;
      row       = 0;
      out_count = 0;
    endfunction

    function logic [CH_W-1:0] rounded_mean(input int unsigned s, input int unsigned n);
      return CH_W'((2 * s + n) / (2 * n));
    endfunction

    function void take_pixel(input logic [CH_W-1:0] r, g, b, input logic fl);
      int unsigned w, h, c, orow, ocol, cnt;
      int unsigned sum [3];
      pix_t        pix, up, mid, v;
      blurred_t    res;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg);
      pix = fl ? '0 : {r, g, b};
      c = (col >= MAX_WIDTH) ? 0 : col;
      up  = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = pix;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = pix;
      if (row >= 2 || (row == 1 && col >= 1)) begin
        if (col == 0) begin
          ocol = w - 1;
          orow = row - 2;
        end else begin
          ocol = col - 1;
          orow = row - 1;
        end
        sum = '{0, 0, 0};
        cnt = 0;
        for (int dr = 0; dr < 3; dr++) begin
          if (dr == 0 && orow == 0) continue;
          if (dr == 2 && orow + 1 >= h) continue;
          for (int dc = 0; dc < 3; dc++) begin
            if (dc == 0 && ocol == 0) continue;
            if (dc == 2 && ocol + 1 >= w) continue;
            v = win[dr][dc];
            sum[0] += v[23:16];
            sum[1] += v[15:8];
            sum[2] += v[7:0];
            cnt++;
          end
        end
        res.red       = rounded_mean(sum[0], cnt);
        res.green     = rounded_mean(sum[1], cnt);
        res.blue      = rounded_mean(sum[2], cnt);
        res.frame_end = (out_count + 1 >= w * h);
        blurred_q.push_back(res);
        if (res.frame_end) begin
          col       = 0;
          row       = 0;
          out_count = 0;
          return;
        end
        out_count++;
      end
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1) & 32'h1fff;
      end else begin
        col++;
      end
    endfunction

    function void check_blurred(input logic [CH_W-1:0] r, g, b, input logic fe);
      blurred_t want;
      if (blurred_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual rgb %0d %0d %0d end %0b",
                 $time, r, g, b, fe);
        errors++;
        return;
      end
      want = blurred_q.pop_front();
      checked++;
      if (want.red !== r) begin
        $display("%0t: red expected %0d actual %0d", $time, want.red, r);
        errors++;
      end
      if (want.green !== g) begin
        $display("%0t: green expected %0d actual %0d", $time, want.green, g);
        errors++;
      end
      if (want.blue !== b) begin
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, b);
        errors++;
      end
      if (want.frame_end !== fe) begin
        $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bb_pix_in_if  pix_in ();
  bb_pix_out_if pix_out ();
  bb_cfg_if     cfg_bus ();

  box_blur_3x3 uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_in),
    .out_pix(pix_out),
    .cfg_wr (cfg_bus)
  );

  blur_scoreboard sb;
  int             beats_in;
  bit             quiet;
  bit             src_calm;
  bit             long_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pix_out.valid && pix_out.ready)
        sb.check_blurred(pix_out.out_red, pix_out.out_green, pix_out.out_blue, pix_out.frame_end);
      if (pix_in.valid && pix_in.ready)
        sb.take_pixel(pix_in.in_red, pix_in.in_green, pix_in.in_blue, pix_in.flush);
      if (cfg_bus.valid && cfg_bus.ready)
        sb.write_reg(cfg_bus.index, cfg_bus.data);
    end
  end

  initial begin
    int span;
    pix_out.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        pix_out.ready <= 1'b0;
        long_hold = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (quiet) begin
        pix_out.ready <= 1'b1;
        @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            pix_out.ready <= 1'b0;
            span = $urandom_range(1, 17);
          end
          1: begin
            pix_out.ready <= 1'b1;
            span = $urandom_range(40, 120);
          end
          default: begin
            pix_out.ready <= 1'b1;
            span = $urandom_range(1, 17);
          end
        endcase
        repeat (span) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic [CH_W-1:0] r, g, b, input logic fl);
    if (!quiet && !src_calm && $urandom_range(0, 5) == 0) begin
      pix_in.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    pix_in.valid    <= 1'b1;
    pix_in.in_red   <= r;
    pix_in.in_green <= g;
    pix_in.in_blue  <= b;
    pix_in.flush    <= fl;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    beats_in++;
  endtask

  // hold the source until every expected result is out and the pipe is empty
  task automatic settle();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_frame(input int pixels, input int drain, input int pause_at);
    for (int i = 0; i < pixels; i++) begin
      if (i == pause_at) settle();
      send_beat(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                CH_W'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
    end
    for (int i = 0; i < drain; i++)
      send_beat(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                CH_W'($urandom_range(0, 255)), $urandom_range(0, 4) != 0);
  endtask

  initial begin
    int                    start, phase, w, h, d, n;
    logic                  clean_end;
    logic [CFG_DATA_W-1:0] wraw, hraw;
    sb = new();
    beats_in  = 0;
    quiet     = 1'b0;
    src_calm  = 1'b0;
    long_hold = 1'b0;
    pix_in.valid    <= 1'b0;
    pix_in.in_red   <= '0;
    pix_in.in_green <= '0;
    pix_in.in_blue  <= '0;
    pix_in.flush    <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= '0;
    cfg_bus.data    <= '0;
    rst_n           <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // 3x2 frame: saturated and dark pixels, a flush inside the frame, drain with junk data
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 2);
    send_beat(8'hff, 8'hff, 8'hff, 1'b0);
    send_beat(8'h00, 8'h00, 8'h00, 1'b0);
    send_beat(8'hff, 8'h00, 8'h01, 1'b0);
    send_beat(8'h80, 8'h7f, 8'hfe, 1'b0);
    send_beat(8'haa, 8'h55, 8'hff, 1'b1);
    send_beat(8'hff, 8'hff, 8'hff, 1'b0);
    repeat (4) send_beat(8'hff, 8'h00, 8'hff, 1'b1);
    settle();

    // single pixel frame
    write_reg(REG_FRAME_HEIGHT, 1);
    write_reg(REG_FRAME_WIDTH, 1);
    send_beat(8'hff, 8'h80, 8'h01, 1'b0);
    repeat (2) send_beat(8'h00, 8'h00, 8'h00, 1'b1);
    settle();

    // unused index: no effect; then a short flush drain finished by two non-flush beats
    write_reg(REG_UNUSED_TOP, '1);
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 1);
    send_beat(8'h10, 8'h20, 8'h30, 1'b0);
    send_beat(8'hf0, 8'he0, 8'hd0, 1'b0);
    send_beat(8'h00, 8'h00, 8'h00, 1'b1);
    send_beat(8'h7f, 8'h80, 8'h81, 1'b0);
    send_beat(8'h01, 8'h02, 8'h03, 1'b0);
    repeat (3) send_beat(8'h5a, 8'ha5, 8'h3c, 1'b1);
    settle();

    // capped width and height; cut short by the next write
    write_reg(REG_FRAME_WIDTH, 13'h0fff);
    write_reg(REG_FRAME_HEIGHT, 13'h1fff);
    run_frame(40, 0, -1);
    settle();

    // single column, tallest frame; width write with the unused top bit set
    write_reg(REG_FRAME_WIDTH, 13'h1001);
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(HEIGHT_CAP));
    run_frame(60, 0, -1);
    settle();
    write_reg(REG_FRAME_HEIGHT, '0);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(MAX_WIDTH));

    start     = beats_in;
    phase     = 0;
    clean_end = 1'b0;
    w         = 1;
    h         = 1;
    while (beats_in - start < RANDOM_BEATS) begin
      quiet    = (beats_in - start >= RANDOM_BEATS - QUIET_BEATS);
      src_calm = ($urandom_range(0, 3) == 0);
      settle();
      if (phase != 3 && phase != 6 && clean_end && $urandom_range(0, 9) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_FRAME_HEIGHT + 1, REG_UNUSED_TOP)),
                  CFG_DATA_W'($urandom));
      end else begin
        if (phase == 3) begin
          w = 24;
          h = 8;
        end else if (phase == 6) begin
          w = $urandom_range(4, 8);
          h = $urandom_range(4, 8);
        end else if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(10, 48);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 8);
        end
        wraw = CFG_DATA_W'(w);
        hraw = CFG_DATA_W'(h);
        if (w == 1 && $urandom_range(0, 1)) wraw = '0;
        if (h == 1 && $urandom_range(0, 1)) hraw = '0;
        if ($urandom_range(0, 3) == 0) wraw[FW_W] = 1'b1;
        if ($urandom_range(0, 1)) begin
          write_reg(REG_FRAME_WIDTH, wraw);
          write_reg(REG_FRAME_HEIGHT, hraw);
        end else begin
          write_reg(REG_FRAME_HEIGHT, hraw);
          write_reg(REG_FRAME_WIDTH, wraw);
        end
      end
      case ($urandom_range(0, 7))
        0:       d = $urandom_range(0, w);
        1:       d = w + 1 + $urandom_range(1, 2 * w);
        default: d = w + 1;
      endcase
      if (phase == 3) begin
        d = w + 1;
        long_hold = 1'b1;
        while (long_hold) @(posedge clk);
      end
      run_frame(w * h, d, (phase == 6) ? (w * h) / 2 : -1);
      clean_end = (d == w + 1);
      phase++;
    end

    pix_in.valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < END_LIMIT && sb.pending() != 0; n++) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());

    $display("%0d pixel beats in, %0d blurred pixels checked over %0d random frames",
             beats_in, sb.checked, phase);
    $display("widths 1 to %0d, heights 1 to %0d, clipped registers, short and long drains, stalls",
             MAX_WIDTH, HEIGHT_CAP);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bb_pkg.sv
src/bb_ifs.sv
src/bb_line_ram.sv
src/bb_window.sv
src/bb_norm.sv
src/bb_out_fifo.sv
src/box_blur_3x3.sv
bench/box_blur_3x3_tb.sv
